FILE: rtl/core/mip_pkg.sv
`default_nettype none

package mip_pkg;

  // Number of channels that own stored drive and error state.
  localparam int CHANNELS = 6;
  localparam int CH_IDX_W = $clog2(CHANNELS);

  // Field widths.
  localparam int CH_W    = 3;
  localparam int SMP_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 17;
  localparam int DRV_W   = 16;
  localparam int LIM_W   = 15;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPPER_LIMIT = 2'd1;

  // Register reset values.
  localparam logic [LIM_W-1:0] MAIN_LIMIT_RST    = 15'd10000;
  localparam logic [LIM_W-1:0] STEPPER_LIMIT_RST = 15'd3900;

  // Channel numbers with a fixed role.
  localparam int LAST_PI_CH  = 3;
  localparam int STEP_NEG_CH = 4;
  localparam int STEP_POS_CH = 5;

  // Division by 256000 = 2048 * 125: shift by 11, then multiply by a
  // reciprocal of 125. The quotient of a 27-bit dividend is exact with
  // M = ceil(2^34 / 125), since 27 bits times the error of 66 stays below 2^34.
  localparam int PRE_SHIFT   = 11;
  localparam int DIVIDEND_W  = 27;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_M = 28'd137438954;
  localparam int QUOT_W      = 21;

  // Control law of a channel.
  typedef enum logic [2:0] {
    MODE_PI,
    MODE_STEP_NEG,
    MODE_STEP_POS,
    MODE_HOLD,
    MODE_NONE
  } mode_t;

  // Map a channel number to its control law.
  function automatic mode_t decode_mode(input logic [CH_W-1:0] ch);
    mode_t m;
    if (int'(ch) >= CHANNELS) begin
      m = MODE_NONE;
    end else if (int'(ch) <= LAST_PI_CH) begin
      m = MODE_PI;
    end else if (int'(ch) == STEP_NEG_CH) begin
      m = MODE_STEP_NEG;
    end else if (int'(ch) == STEP_POS_CH) begin
      m = MODE_STEP_POS;
    end else begin
      m = MODE_HOLD;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/multichannel_incremental_pi_top.sv
// Items pass registers s1 to s4 and then the output register. Throughput: one
// item per cycle while result_stall is low; the drive read-modify-write in the
// last stage forwards the most recent write, so a channel may repeat back to back.
// Reset (synchronous, rst high) clears the entry valid bits, so every stored drive
// and last error reads as zero, and sets the limits to 10000 and 3900.
// The stores get no clearing pass; the block accepts items right after reset.
`default_nettype none

module multichannel_incremental_pi_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Sample channel
  input  wire logic                               sample_valid,
  output logic                                    sample_stall,
  input  wire logic [mip_pkg::CH_W-1:0]           channel,
  input  wire logic signed [mip_pkg::SMP_W-1:0]   measured,
  input  wire logic signed [mip_pkg::SMP_W-1:0]   target,
  input  wire logic [mip_pkg::GAIN_W-1:0]         kp_gain,
  input  wire logic [mip_pkg::GAIN_W-1:0]         ki_gain,
  // Result channel
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic [mip_pkg::CH_W-1:0]                out_channel,
  output logic signed [mip_pkg::DRV_W-1:0]        drive,
  // Configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mip_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mip_pkg::LIM_W-1:0]          cfg_data
);

  localparam int IW   = mip_pkg::CH_IDX_W;
  localparam int P1_W = 39;
  localparam int P2_W = 34;
  localparam int SUM_W = 40;
  localparam int PROD_W = mip_pkg::DIVIDEND_W + mip_pkg::RECIP_W;
  localparam int T_W  = mip_pkg::QUOT_W + 1;
  localparam int PRE_W = 24;

  typedef struct packed {
    logic [mip_pkg::CH_W-1:0]         ch;
    mip_pkg::mode_t                   mode;
    logic signed [mip_pkg::SMP_W-1:0] meas;
    logic signed [mip_pkg::SMP_W-1:0] targ;
    logic [mip_pkg::GAIN_W-1:0]       kp;
    logic [mip_pkg::GAIN_W-1:0]       ki;
  } s1_t;

  typedef struct packed {
    logic [mip_pkg::CH_W-1:0] ch;
    mip_pkg::mode_t           mode;
    logic signed [P1_W-1:0]   p1;
    logic signed [P2_W-1:0]   p2;
  } s2_t;

  typedef struct packed {
    logic [mip_pkg::CH_W-1:0]       ch;
    mip_pkg::mode_t                 mode;
    logic                           neg;
    logic [mip_pkg::DIVIDEND_W-1:0] m;
  } s3_t;

  typedef struct packed {
    logic [mip_pkg::CH_W-1:0]   ch;
    mip_pkg::mode_t             mode;
    logic                       neg;
    logic [mip_pkg::QUOT_W-1:0] q;
  } s4_t;

  // Configuration registers; writes are always taken.
  logic [mip_pkg::LIM_W-1:0] main_limit;
  logic [mip_pkg::LIM_W-1:0] stepper_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_limit    <= mip_pkg::MAIN_LIMIT_RST;
      stepper_limit <= mip_pkg::STEPPER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mip_pkg::CFG_MAIN_LIMIT:    main_limit    <= cfg_data;
        mip_pkg::CFG_STEPPER_LIMIT: stepper_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and the ready chain from the output register back.
  logic s1_v, s2_v, s3_v, s4_v;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !result_valid || !result_stall;
  assign rdy4 = !s4_v || rdy5;
  assign rdy3 = !s3_v || rdy4;
  assign rdy2 = !s2_v || rdy3;
  assign rdy1 = !s1_v || rdy2;
  assign sample_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      s4_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) s1_v <= sample_valid;
      if (rdy2) s2_v <= s1_v;
      if (rdy3) s3_v <= s2_v;
      if (rdy4) s4_v <= s3_v;
      if (rdy5) result_valid <= s4_v;
    end
  end

  // Stage 1: take the item and read the channel's last error.
  s1_t            s1;
  mip_pkg::mode_t in_mode;
  logic           le_rd_en;
  logic [mip_pkg::ERR_W-1:0] le_rd;
  logic           le_rd_ok;
  logic [mip_pkg::CHANNELS-1:0] le_ok;

  assign in_mode  = mip_pkg::decode_mode(channel);
  assign le_rd_en = rdy1 && sample_valid && (in_mode != mip_pkg::MODE_NONE);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1.ch   <= channel;
      s1.mode <= in_mode;
      s1.meas <= measured;
      s1.targ <= target;
      s1.kp   <= kp_gain;
      s1.ki   <= ki_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      le_rd_ok <= 1'b0;
    end else if (rdy1) begin
      le_rd_ok <= le_rd_en ? le_ok[channel[IW-1:0]] : 1'b0;
    end
  end

  // Last-error forwarding: the most recent write wins over the RAM read.
  logic                      le_we;
  logic                      le_fwd_v;
  logic [mip_pkg::CH_W-1:0]  le_fwd_ch;
  logic signed [mip_pkg::ERR_W-1:0] le_fwd_val;
  logic signed [mip_pkg::ERR_W-1:0] err;
  logic signed [mip_pkg::ERR_W-1:0] last_err;
  logic signed [mip_pkg::ERR_W:0]   de;
  logic [19:0]                      kp10;

  assign le_we = s1_v && rdy2 && (s1.mode != mip_pkg::MODE_NONE);

  always_comb begin
    err = mip_pkg::ERR_W'(s1.meas) - mip_pkg::ERR_W'(s1.targ);
    if (le_fwd_v && le_fwd_ch == s1.ch) begin
      last_err = le_fwd_val;
    end else if (le_rd_ok) begin
      last_err = $signed(le_rd);
    end else begin
      last_err = '0;
    end
    de = (mip_pkg::ERR_W + 1)'(err) - (mip_pkg::ERR_W + 1)'(last_err);
    // Ten times kp, only used by the PI channels.
    if (s1.mode == mip_pkg::MODE_PI) begin
      kp10 = {1'b0, s1.kp, 3'b000} + {3'b000, s1.kp, 1'b0};
    end else begin
      kp10 = '0;
    end
  end

  mip_ram #(
    .WIDTH (mip_pkg::ERR_W),
    .DEPTH (mip_pkg::CHANNELS)
  ) u_last_err_ram (
    .clk     (clk),
    .rd_en   (le_rd_en),
    .rd_addr (channel[IW-1:0]),
    .rd_data (le_rd),
    .wr_en   (le_we),
    .wr_addr (s1.ch[IW-1:0]),
    .wr_data (err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      le_ok    <= '0;
      le_fwd_v <= 1'b0;
    end else if (le_we) begin
      le_ok[s1.ch[IW-1:0]] <= 1'b1;
      le_fwd_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (le_we) begin
      le_fwd_ch  <= s1.ch;
      le_fwd_val <= err;
    end
  end

  // Stage 1 products: 10*kp*de and ki*err.
  s2_t s2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2.ch   <= s1.ch;
      s2.mode <= s1.mode;
      s2.p1   <= $signed({1'b0, kp10}) * de;
      s2.p2   <= $signed({1'b0, s1.ki}) * err;
    end
  end

  // Stage 2: sum, magnitude and the shift by 2048.
  s3_t s3;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        mag;

  always_comb begin
    sum = SUM_W'(s2.p1) + SUM_W'(s2.p2);
    mag = sum[SUM_W-1] ? 0 - sum : sum;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3.ch   <= s2.ch;
      s3.mode <= s2.mode;
      s3.neg  <= sum[SUM_W-1];
      s3.m    <= mip_pkg::DIVIDEND_W'(mag >> mip_pkg::PRE_SHIFT);
    end
  end

  // Stage 3: divide by 125 through the reciprocal; issue the drive read.
  s4_t s4;
  logic [PROD_W-1:0] prod;
  logic              drv_rd_en;

  assign prod      = s3.m * mip_pkg::RECIP_M;
  assign drv_rd_en = rdy4 && s3_v && (s3.mode != mip_pkg::MODE_NONE);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4.ch   <= s3.ch;
      s4.mode <= s3.mode;
      s4.neg  <= s3.neg;
      s4.q    <= mip_pkg::QUOT_W'(prod >> mip_pkg::RECIP_SHIFT);
    end
  end

  logic [mip_pkg::DRV_W-1:0]    drv_rd;
  logic                         drv_rd_ok;
  logic [mip_pkg::CHANNELS-1:0] drv_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      drv_rd_ok <= 1'b0;
    end else if (rdy4) begin
      drv_rd_ok <= drv_rd_en ? drv_ok[s3.ch[IW-1:0]] : 1'b0;
    end
  end

  // Stage 4: apply the increment (to the stored drive on PI channels) and clamp.
  logic                             drv_we;
  logic                             drv_fwd_v;
  logic [mip_pkg::CH_W-1:0]         drv_fwd_ch;
  logic signed [mip_pkg::DRV_W-1:0] drv_fwd_val;
  logic signed [mip_pkg::DRV_W-1:0] drv_old;
  logic signed [T_W-1:0]            tq;
  logic signed [T_W-1:0]            t;
  logic signed [PRE_W-1:0]          pre;
  logic signed [PRE_W-1:0]          lim_w;
  logic signed [PRE_W-1:0]          neg_lim;
  logic signed [mip_pkg::DRV_W-1:0] drv_new;

  assign drv_we = s4_v && rdy5 && (s4.mode != mip_pkg::MODE_NONE);

  always_comb begin
    if (drv_fwd_v && drv_fwd_ch == s4.ch) begin
      drv_old = drv_fwd_val;
    end else if (drv_rd_ok) begin
      drv_old = $signed(drv_rd);
    end else begin
      drv_old = '0;
    end
    tq = $signed({1'b0, s4.q});
    t  = s4.neg ? -tq : tq;
    case (s4.mode)
      mip_pkg::MODE_PI:       pre = PRE_W'(drv_old) - PRE_W'(t);
      mip_pkg::MODE_STEP_NEG: pre = -PRE_W'(t);
      mip_pkg::MODE_STEP_POS: pre = PRE_W'(t);
      mip_pkg::MODE_HOLD:     pre = PRE_W'(drv_old);
      default:                pre = '0;
    endcase
    if (s4.mode == mip_pkg::MODE_PI) begin
      lim_w = $signed({{(PRE_W - mip_pkg::LIM_W){1'b0}}, main_limit});
    end else begin
      lim_w = $signed({{(PRE_W - mip_pkg::LIM_W){1'b0}}, stepper_limit});
    end
    neg_lim = -lim_w;
    if (pre > lim_w) begin
      drv_new = lim_w[mip_pkg::DRV_W-1:0];
    end else if (pre < neg_lim) begin
      drv_new = neg_lim[mip_pkg::DRV_W-1:0];
    end else begin
      drv_new = pre[mip_pkg::DRV_W-1:0];
    end
  end

  mip_ram #(
    .WIDTH (mip_pkg::DRV_W),
    .DEPTH (mip_pkg::CHANNELS)
  ) u_drive_ram (
    .clk     (clk),
    .rd_en   (drv_rd_en),
    .rd_addr (s3.ch[IW-1:0]),
    .rd_data (drv_rd),
    .wr_en   (drv_we),
    .wr_addr (s4.ch[IW-1:0]),
    .wr_data (drv_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      drv_ok    <= '0;
      drv_fwd_v <= 1'b0;
    end else if (drv_we) begin
      drv_ok[s4.ch[IW-1:0]] <= 1'b1;
      drv_fwd_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drv_we) begin
      drv_fwd_ch  <= s4.ch;
      drv_fwd_val <= drv_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_channel <= s4.ch;
      drive       <= drv_new;
    end
  end

`ifndef SYNTHESIS
  // A stalled input means every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (s1_v && s2_v && s3_v && s4_v && result_valid))
    else $error("input stalled while the pipeline has a free stage");

  // The drive written back is the drive that is presented next.
  a_wb_matches_out: assert property (@(posedge clk) disable iff (rst)
    drv_we |=> (result_valid && drive == $past(drv_new)))
    else $error("stored drive differs from the presented drive");

  // A PI channel's stored drive lies within the main limit.
  a_pi_clamp: assert property (@(posedge clk) disable iff (rst)
    (drv_we && s4.mode == mip_pkg::MODE_PI) |->
      ($signed(PRE_W'(drv_new)) <= lim_w && $signed(PRE_W'(drv_new)) >= neg_lim))
    else $error("PI drive outside the main limit");

  // No result in the first cycle after reset is released.
  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mip_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module mip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
